@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// plain property check on a clock, disabled in reset
`define POI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// implication check, antecedent then consequent in the next cycle
`define POI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define POI_ASSERT(lbl, clk, rst_n, prop)
`define POI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/poi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poi_pkg
// constants, widths and the arctangent table for the odometry integrator
// ----------------------------------------------------------------------------
package poi_pkg;

    localparam int CORD_W = 34;   // cordic datapath width
    localparam int DIV_NW = 50;   // divider numerator width
    localparam int MUL_AW = 36;
    localparam int MUL_BW = 32;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    localparam logic signed [31:0] ANG_PER_RAD = 32'sd683565276;
    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/poi_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poi_stream_if
// valid/ready channels for update items and pose results
// ----------------------------------------------------------------------------
interface poi_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_rot;
    logic signed [31:0] left_dist;
    logic signed [31:0] right_dist;
    logic [15:0]        time_step;

    modport source (output valid, opcode, vel_x, vel_y, vel_rot, left_dist, right_dist,
                    time_step, input ready);
    modport sink (input valid, opcode, vel_x, vel_y, vel_rot, left_dist, right_dist,
                  time_step, output ready);
endinterface

interface poi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic signed [31:0] heading_out;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic signed [31:0] turn_rate;

    modport source (output valid, pos_x_out, pos_y_out, heading_out, speed_x, speed_y,
                    turn_rate, input ready);
    modport sink (input valid, pos_x_out, pos_y_out, heading_out, speed_x, speed_y,
                  turn_rate, output ready);
endinterface

@@ hw/rtl/poi_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poi_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module poi_mul
    import poi_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_AW-1:0] i_a,
    input  logic signed [MUL_BW-1:0] i_b,
    output logic signed [MUL_PW-1:0] o_p
);
    logic signed [MUL_PW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_PW'(i_a) * MUL_PW'(i_b);
    end

    assign o_p = r_p;
endmodule

@@ hw/rtl/poi_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poi_cordic
// rotation-mode cordic, one micro-rotation per cycle, quadrant fixed at end
// ----------------------------------------------------------------------------
module poi_cordic
    import poi_pkg::*;
#(
    parameter int STEPS = 24
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_angle,
    output logic               o_done,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);
    localparam int IW = $clog2(STEPS + 1);

    logic                     r_busy;
    logic                     r_done;
    logic [IW-1:0]            r_i;
    logic [1:0]               r_k;
    logic signed [CORD_W-1:0] r_x;
    logic signed [CORD_W-1:0] r_y;
    logic signed [CORD_W-1:0] r_z;
    logic signed [31:0]       r_cos;
    logic signed [31:0]       r_sin;

    logic [31:0]              w_ka;
    logic [31:0]              w_res;
    logic signed [CORD_W-1:0] w_atan;

    assign w_ka   = i_angle + 32'h2000_0000;
    assign w_res  = i_angle - {w_ka[31:30], 30'b0};
    assign w_atan = signed'({2'b00, atan_lut(5'(r_i))});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_i == IW'(STEPS)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_i <= '0;
            r_k <= w_ka[31:30];
            r_x <= CORDIC_GAIN;
            r_y <= '0;
            r_z <= CORD_W'(signed'(w_res));
        end else if (r_busy && r_i != IW'(STEPS)) begin
            r_i <= r_i + 1'b1;
            if (!r_z[CORD_W-1]) begin
                r_x <= r_x - (r_y >>> r_i);
                r_y <= r_y + (r_x >>> r_i);
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + (r_y >>> r_i);
                r_y <= r_y - (r_x >>> r_i);
                r_z <= r_z + w_atan;
            end
        end else if (r_busy) begin
            // exact quarter-turn on the finished residual rotation
            case (r_k)
                2'd1: begin
                    r_cos <= 32'(-r_y);
                    r_sin <= 32'(r_x);
                end
                2'd2: begin
                    r_cos <= 32'(-r_x);
                    r_sin <= 32'(-r_y);
                end
                2'd3: begin
                    r_cos <= 32'(r_y);
                    r_sin <= 32'(-r_x);
                end
                default: begin
                    r_cos <= 32'(r_x);
                    r_sin <= 32'(r_y);
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;
endmodule

@@ hw/rtl/poi_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poi_div
// restoring divider, one quotient bit per cycle, truncating, 32-bit saturated
// ----------------------------------------------------------------------------
module poi_div
    import poi_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DIV_NW-1:0] i_num,
    input  logic [30:0]              i_den,
    output logic                     o_done,
    output logic signed [31:0]       o_quot
);
    localparam int CW = $clog2(DIV_NW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic              r_neg;
    logic [DIV_NW-1:0] r_q;
    logic [31:0]       r_rem;
    logic [30:0]       r_den;
    logic signed [31:0] r_quot;

    logic [31:0]       w_rem2;
    logic              w_ge;

    assign w_rem2 = {r_rem[30:0], r_q[DIV_NW-1]};
    assign w_ge   = w_rem2 >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(DIV_NW)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_neg <= i_num[DIV_NW-1];
            r_q   <= i_num[DIV_NW-1] ? DIV_NW'(-i_num) : DIV_NW'(i_num);
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy && r_cnt != CW'(DIV_NW)) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= w_ge ? (w_rem2 - {1'b0, r_den}) : w_rem2;
            r_q   <= {r_q[DIV_NW-2:0], w_ge};
        end else if (r_busy) begin
            if (!r_neg && r_q > DIV_NW'(32'h7FFF_FFFF)) begin
                r_quot <= 32'sh7FFF_FFFF;
            end else if (r_neg && r_q > DIV_NW'(32'h8000_0000)) begin
                r_quot <= 32'sh8000_0000;
            end else if (r_neg) begin
                r_quot <= 32'(-r_q);
            end else begin
                r_quot <= 32'(r_q);
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

@@ hw/rtl/planar_odometry_integrator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_odometry_integrator_unit
// dead-reckoning pose integrator, body velocity or wheel encoder updates
// ----------------------------------------------------------------------------
// channel     dir  handshake    payload
// i_in_bus    in   valid/ready  opcode, velocities, wheel distances, time_step
// o_out_bus   out  valid/ready  pose, heading, reported velocities
// i_cfg_*     in   write enable wheel_spacing
//
// opcode 0 goes through the multiplier and the cordic unit only; opcode 1
// also uses the bit-serial divider, in three passes; both opcodes run the
// cordic unit twice
// ready is high only while idle; one result can wait in the output register
// while the next beat is taken
// reset is synchronous, pose and wheel history clear to zero
`include "assert_macros.svh"
module planar_odometry_integrator_unit
    import poi_pkg::*;
#(
    parameter int CORDIC_STEPS = 24
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    poi_in_if.sink      i_in_bus,
    poi_out_if.source   o_out_bus,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_wdata
);
    typedef enum logic [20:0] {
        ST_IDLE   = 21'd1 << 0,
        ST_M_DTH  = 21'd1 << 1,
        ST_DIV_TH = 21'd1 << 2,
        ST_M_ANG  = 21'd1 << 3,
        ST_DIV_SX = 21'd1 << 4,
        ST_DIV_SR = 21'd1 << 5,
        ST_CORD_A = 21'd1 << 6,
        ST_M_BX1  = 21'd1 << 7,
        ST_M_BX2  = 21'd1 << 8,
        ST_M_BY1  = 21'd1 << 9,
        ST_M_BY2  = 21'd1 << 10,
        ST_M_DX   = 21'd1 << 11,
        ST_M_DY   = 21'd1 << 12,
        ST_M_E1   = 21'd1 << 13,
        ST_M_E2   = 21'd1 << 14,
        ST_CORD_H = 21'd1 << 15,
        ST_M_P1   = 21'd1 << 16,
        ST_M_P2   = 21'd1 << 17,
        ST_M_P3   = 21'd1 << 18,
        ST_M_P4   = 21'd1 << 19,
        ST_DONE   = 21'd1 << 20
    } t_state;

    t_state r_st;
    t_state n_st;
    logic   r_ph;
    logic   n_ph;
    logic   r_ov;

    logic [30:0]        r_ws;
    logic [31:0]        r_pos_x;
    logic [31:0]        r_pos_y;
    logic [31:0]        r_heading;
    logic [31:0]        r_last_l;
    logic [31:0]        r_last_r;

    logic               r_op;
    logic signed [31:0] r_vx;
    logic signed [31:0] r_vy;
    logic signed [31:0] r_vr;
    logic [31:0]        r_l;
    logic [31:0]        r_r;
    logic [15:0]        r_dt;
    logic signed [31:0] r_dth;
    logic [31:0]        r_ang;
    logic signed [31:0] r_c;
    logic signed [31:0] r_s;
    logic signed [33:0] r_bx;
    logic signed [33:0] r_by;
    logic signed [33:0] r_dx;
    logic signed [33:0] r_dy;
    logic signed [31:0] r_davg;
    logic signed [31:0] r_sx;
    logic signed [31:0] r_sr;
    logic signed [37:0] r_px;
    logic signed [37:0] r_py;

    logic signed [31:0] r_o_px;
    logic signed [31:0] r_o_py;
    logic signed [31:0] r_o_hd;
    logic signed [31:0] r_o_sx;
    logic signed [31:0] r_o_sy;
    logic signed [31:0] r_o_sr;

    logic signed [MUL_AW-1:0] w_mul_a;
    logic signed [MUL_BW-1:0] w_mul_b;
    logic signed [MUL_PW-1:0] w_p;
    logic signed [33:0]       w_p30;
    logic signed [33:0]       w_p16;

    logic               w_cd_start;
    logic               w_cd_done;
    logic [31:0]        w_cd_ang;
    logic signed [31:0] w_cos;
    logic signed [31:0] w_sin;

    logic                     w_dv_start;
    logic                     w_dv_done;
    logic signed [DIV_NW-1:0] w_dv_num;
    logic [30:0]              w_dv_den;
    logic signed [31:0]       w_quot;

    logic signed [31:0] w_dl;
    logic signed [31:0] w_dr;
    logic signed [32:0] w_diff;
    logic signed [32:0] w_sum;
    logic [30:0]        w_ws_eff;
    logic [15:0]        w_dt_eff;
    logic               w_accept;
    logic               w_load;
    logic               w_is_mul;
    logic               w_is_div;
    logic               w_is_cord;

    function automatic logic [31:0] sat38(input logic signed [37:0] v);
        logic [31:0] r;
        if (v > 38'sh7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -38'sh8000_0000) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign w_accept = i_in_bus.valid && i_in_bus.ready;
    assign w_load   = (r_st == ST_DONE) && (!r_ov || o_out_bus.ready);
    assign i_in_bus.ready = (r_st == ST_IDLE);

    assign w_dl     = signed'(r_l - r_last_l);
    assign w_dr     = signed'(r_r - r_last_r);
    assign w_diff   = 33'(w_dl) - 33'(w_dr);
    assign w_sum    = 33'(w_dl) + 33'(w_dr);
    assign w_ws_eff = (r_ws == '0) ? 31'd1 : r_ws;
    assign w_dt_eff = (r_dt == '0) ? 16'd1 : r_dt;

    assign w_p30 = 34'(w_p >>> 30);
    assign w_p16 = 34'(w_p >>> 16);

    assign w_is_mul = (r_st == ST_M_DTH) || (r_st == ST_M_ANG) || (r_st == ST_M_BX1) ||
                      (r_st == ST_M_BX2) || (r_st == ST_M_BY1) || (r_st == ST_M_BY2) ||
                      (r_st == ST_M_DX) || (r_st == ST_M_DY) || (r_st == ST_M_E1) ||
                      (r_st == ST_M_E2) || (r_st == ST_M_P1) || (r_st == ST_M_P2) ||
                      (r_st == ST_M_P3) || (r_st == ST_M_P4);
    assign w_is_div  = (r_st == ST_DIV_TH) || (r_st == ST_DIV_SX) || (r_st == ST_DIV_SR);
    assign w_is_cord = (r_st == ST_CORD_A) || (r_st == ST_CORD_H);

    assign w_cd_start = w_is_cord && !r_ph;
    assign w_cd_ang   = (r_st == ST_CORD_H) ? r_heading : r_ang;
    assign w_dv_start = w_is_div && !r_ph;

    // operand select for the shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_st)
            ST_M_DTH: begin
                w_mul_a = MUL_AW'(r_vr);
                w_mul_b = signed'({16'b0, r_dt});
            end
            ST_M_ANG: begin
                w_mul_a = MUL_AW'(r_dth);
                w_mul_b = ANG_PER_RAD;
            end
            ST_M_BX1, ST_M_BY2: begin
                w_mul_a = MUL_AW'(ST_M_BX1 == r_st ? r_vx : r_vy);
                w_mul_b = r_c;
            end
            ST_M_BX2, ST_M_BY1: begin
                w_mul_a = MUL_AW'(ST_M_BX2 == r_st ? r_vy : r_vx);
                w_mul_b = r_s;
            end
            ST_M_DX: begin
                w_mul_a = MUL_AW'(r_bx);
                w_mul_b = signed'({16'b0, r_dt});
            end
            ST_M_DY: begin
                w_mul_a = MUL_AW'(r_by);
                w_mul_b = signed'({16'b0, r_dt});
            end
            ST_M_E1: begin
                w_mul_a = MUL_AW'(r_davg);
                w_mul_b = r_c;
            end
            ST_M_E2: begin
                w_mul_a = MUL_AW'(r_davg);
                w_mul_b = r_s;
            end
            ST_M_P1, ST_M_P3: begin
                w_mul_a = MUL_AW'(r_dx);
                w_mul_b = (r_st == ST_M_P1) ? r_c : r_s;
            end
            ST_M_P2, ST_M_P4: begin
                w_mul_a = MUL_AW'(r_dy);
                w_mul_b = (r_st == ST_M_P2) ? r_s : r_c;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_comb begin
        w_dv_num = '0;
        w_dv_den = 31'(w_dt_eff);
        case (r_st)
            ST_DIV_TH: begin
                w_dv_num = DIV_NW'(signed'({w_diff, 16'h0}));
                w_dv_den = w_ws_eff;
            end
            ST_DIV_SX: w_dv_num = DIV_NW'(signed'({r_davg, 16'h0}));
            ST_DIV_SR: w_dv_num = DIV_NW'(signed'({r_dth, 16'h0}));
            default: w_dv_num = '0;
        endcase
    end

    always_comb begin
        n_st = r_st;
        n_ph = r_ph;
        case (r_st)
            ST_IDLE: begin
                if (w_accept) begin
                    n_st = i_in_bus.opcode ? ST_DIV_TH : ST_M_DTH;
                    n_ph = 1'b0;
                end
            end
            ST_DONE: begin
                if (w_load) begin
                    n_st = ST_IDLE;
                end
            end
            default: begin
                if (w_is_mul) begin
                    n_ph = ~r_ph;
                end else if (!r_ph) begin
                    n_ph = 1'b1;
                end else if ((w_is_div && w_dv_done) || (w_is_cord && w_cd_done)) begin
                    n_ph = 1'b0;
                end
                if (n_ph == 1'b0 && r_ph == 1'b1) begin
                    case (r_st)
                        ST_M_DTH:  n_st = ST_M_ANG;
                        ST_DIV_TH: n_st = ST_M_ANG;
                        ST_M_ANG:  n_st = r_op ? ST_DIV_SX : ST_CORD_A;
                        ST_DIV_SX: n_st = ST_DIV_SR;
                        ST_DIV_SR: n_st = ST_CORD_A;
                        ST_CORD_A: n_st = r_op ? ST_M_E1 : ST_M_BX1;
                        ST_M_BX1:  n_st = ST_M_BX2;
                        ST_M_BX2:  n_st = ST_M_BY1;
                        ST_M_BY1:  n_st = ST_M_BY2;
                        ST_M_BY2:  n_st = ST_M_DX;
                        ST_M_DX:   n_st = ST_M_DY;
                        ST_M_DY:   n_st = ST_CORD_H;
                        ST_M_E1:   n_st = ST_M_E2;
                        ST_M_E2:   n_st = ST_CORD_H;
                        ST_CORD_H: n_st = ST_M_P1;
                        ST_M_P1:   n_st = ST_M_P2;
                        ST_M_P2:   n_st = ST_M_P3;
                        ST_M_P3:   n_st = ST_M_P4;
                        ST_M_P4:   n_st = ST_DONE;
                        default:   n_st = ST_IDLE;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_IDLE;
            r_ph      <= 1'b0;
            r_ov      <= 1'b0;
            r_ws      <= 31'd19661;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_heading <= '0;
            r_last_l  <= '0;
            r_last_r  <= '0;
        end else begin
            r_st <= n_st;
            r_ph <= n_ph;
            if (i_cfg_we) begin
                r_ws <= i_cfg_wdata;
            end
            if (w_load) begin
                r_ov      <= 1'b1;
                r_pos_x   <= sat38(r_px);
                r_pos_y   <= sat38(r_py);
                r_heading <= r_heading + r_ang;
                if (r_op) begin
                    r_last_l <= r_l;
                    r_last_r <= r_r;
                end
            end else if (o_out_bus.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath registers: inputs on accept, r_davg as ST_DIV_TH starts, the rest when their step finishes
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= i_in_bus.opcode;
            r_vx <= i_in_bus.vel_x;
            r_vy <= i_in_bus.vel_y;
            r_vr <= i_in_bus.vel_rot;
            r_l  <= i_in_bus.left_dist;
            r_r  <= i_in_bus.right_dist;
            r_dt <= i_in_bus.time_step;
        end
        if (r_st == ST_DIV_TH && !r_ph) begin
            r_davg <= w_sum[32:1];
        end
        if (w_cd_done) begin
            r_c <= w_cos;
            r_s <= w_sin;
        end
        if (w_dv_done) begin
            case (r_st)
                ST_DIV_TH: r_dth <= w_quot;
                ST_DIV_SX: r_sx  <= w_quot;
                default:   r_sr  <= w_quot;
            endcase
        end
        if (w_is_mul && r_ph) begin
            case (r_st)
                ST_M_DTH: r_dth <= 32'(w_p16);
                ST_M_ANG: r_ang <= 32'(w_p >>> 16);
                ST_M_BX1: r_bx  <= w_p30;
                ST_M_BX2: r_bx  <= r_bx - w_p30;
                ST_M_BY1: r_by  <= w_p30;
                ST_M_BY2: r_by  <= r_by + w_p30;
                ST_M_DX:  r_dx  <= w_p16;
                ST_M_DY:  r_dy  <= w_p16;
                ST_M_E1:  r_dx  <= w_p30;
                ST_M_E2:  r_dy  <= -w_p30;
                ST_M_P1:  r_px  <= 38'(signed'(r_pos_x)) + 38'(w_p30);
                ST_M_P2:  r_px  <= r_px - 38'(w_p30);
                ST_M_P3:  r_py  <= 38'(signed'(r_pos_y)) + 38'(w_p30);
                default:  r_py  <= r_py + 38'(w_p30);
            endcase
        end
        if (w_load) begin
            r_o_px <= signed'(sat38(r_px));
            r_o_py <= signed'(sat38(r_py));
            r_o_hd <= signed'(r_heading + r_ang);
            r_o_sx <= r_op ? r_sx : r_vx;
            r_o_sy <= r_op ? 32'sd0 : r_vy;
            r_o_sr <= r_op ? r_sr : r_vr;
        end
    end

    assign o_out_bus.valid       = r_ov;
    assign o_out_bus.pos_x_out   = r_o_px;
    assign o_out_bus.pos_y_out   = r_o_py;
    assign o_out_bus.heading_out = r_o_hd;
    assign o_out_bus.speed_x     = r_o_sx;
    assign o_out_bus.speed_y     = r_o_sy;
    assign o_out_bus.turn_rate   = r_o_sr;

    poi_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_p)
    );

    poi_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cd_start),
        .i_angle (w_cd_ang),
        .o_done  (w_cd_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    poi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dv_start),
        .i_num   (w_dv_num),
        .i_den   (w_dv_den),
        .o_done  (w_dv_done),
        .o_quot  (w_quot)
    );

    `POI_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, w_accept, !i_in_bus.ready)
    `POI_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, w_load, r_ov && r_st == ST_IDLE)
    `POI_ASSERT(a_cordic_done_owned, i_clk, i_rst_n, !w_cd_done || w_is_cord)
    `POI_ASSERT(a_div_done_owned, i_clk, i_rst_n, !w_dv_done || w_is_div)
endmodule
